### design/pdz_pkg.sv
// ----------------------------------------------------------------------------
// pdz_pkg
// shared types and constants for the dead-zone pid controller
// ----------------------------------------------------------------------------
package pdz_pkg;

    // register indexes on the configuration port
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_LIMIT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_BAND    = 3'd4;

    localparam int DATA_W = 32;
    localparam int UQ_W   = 31;

    localparam logic [UQ_W-1:0] LIMIT_RESET = 31'h7FFF_FFFF;

    // rounding offsets and derivative saturation
    localparam logic [63:0] ROUND_Q16 = 64'h0000_0000_0000_8000;
    localparam logic [63:0] BIAS_2_32 = 64'h0000_0001_0000_0000;
    localparam logic [63:0] DERIV_CAP = 64'h4000_0000_0000_0000;

    // divider: two quotient bits a cycle over a 64-bit dividend
    localparam int DIV_CYCLES = 32;
    localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_CYCLES - 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DEAD,
        ST_SUMS,
        ST_MAGS,
        ST_MUL_P,
        ST_MUL_I,
        ST_MUL_ILO,
        ST_MUL_IHI,
        ST_MUL_D,
        ST_DIV_SETUP,
        ST_DIV,
        ST_DCAP,
        ST_SUM_PI,
        ST_SUM_D,
        ST_CLAMP
    } pdz_state_t;

endpackage

### design/pid_dead_zone_controller.sv
// ----------------------------------------------------------------------------
// pid_dead_zone_controller
// fixed-point Q16.16 pid controller with a continuous error dead zone
//
// a request on the s_ channel carries time_step, target and feedback; one
// result per request leaves on the m_ channel as drive. gains, output limit
// and dead band are written through the cfg_ port; the user must write them
// only while the block is idle, as the block itself does not enforce it.
// a request runs through the dead zone, the five products, the restoring
// divider for the derivative (two quotient bits a cycle over 64 bits) and
// the sums to the clamp; when time_step is zero the derivative and divider
// are skipped. the single 32x32 multiplier serves all five products in turn.
// a new request is taken only after the last result is loaded for output.
// s_ready is high only while the sequencer is idle. the result sits in an
// output register, so a stalled receiver does not hold up the next request;
// only a second result waits in the final step until m_ready frees the slot.
// reset (aresetn low, synchronous) clears the integral and previous error,
// loads the register defaults and empties the output register.
// ----------------------------------------------------------------------------
module pid_dead_zone_controller (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration writes
    input  logic                              cfg_wr_en,
    input  logic [pdz_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pdz_pkg::DATA_W-1:0]        cfg_wr_data,
    // request channel
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [pdz_pkg::UQ_W-1:0]          s_time_step,
    input  logic signed [pdz_pkg::DATA_W-1:0] s_target,
    input  logic signed [pdz_pkg::DATA_W-1:0] s_feedback,
    // result channel
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [pdz_pkg::DATA_W-1:0] m_drive
);

    // magnitude of a 33-bit signed value
    function automatic logic [32:0] abs33(input logic signed [32:0] v);
        logic [32:0] r;
        r = v[32] ? 33'(-v) : 33'(v);
        return r;
    endfunction

    // symmetric clamp of a wide value to +-lim
    function automatic logic signed [31:0] clamp_lim(input logic signed [63:0] v,
                                                     input logic [30:0] lim);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        logic signed [31:0] r;
        hi = $signed({33'd0, lim});
        lo = -hi;
        if (v > hi) begin
            r = hi[31:0];
        end else if (v < lo) begin
            r = lo[31:0];
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // configuration
    logic signed [31:0] prop_gain_reg, integ_gain_reg, deriv_gain_reg;
    logic [30:0]        output_limit_reg, dead_band_reg;

    // controller state
    logic signed [31:0] prev_err_reg, integral_reg;

    // sequencer
    pdz_pkg::pdz_state_t state_reg, state_next;
    logic [pdz_pkg::DIV_CNT_W-1:0] cnt_reg;

    // datapath registers
    logic [30:0]        dt_reg;
    logic signed [32:0] e_reg;
    logic signed [31:0] err_reg;
    logic signed [32:0] s_reg, diff_reg;
    logic [31:0]        err_mag_reg, kp_mag_reg, ki_mag_reg, kd_mag_reg;
    logic [32:0]        s_mag_reg, diff_mag_reg;
    logic               sp_reg, si_reg, sd_reg;
    logic [63:0]        prod_reg;
    logic [46:0]        p_mag_reg;
    logic [63:0]        mi_reg;
    logic [31:0]        xh_reg;
    logic [61:0]        inc_mag_reg;
    logic signed [62:0] inc_reg;
    logic [63:0]        div_reg;
    logic [30:0]        rem_reg;
    logic signed [47:0] p_reg;
    logic signed [63:0] d_reg;
    logic signed [63:0] acc_reg;
    logic signed [31:0] drive_reg;
    logic               m_valid_reg;

    // shared multiplier operands
    logic [31:0] mul_a, mul_b;

    // combinational helpers
    logic signed [33:0] e34, db34, dz_hi, dz_lo, dz;
    logic signed [31:0] err_dz;
    logic [32:0]        err_abs, s_abs, diff_abs, kp_abs, ki_abs, kd_abs;
    logic [63:0]        p_round, x_sum, a_sum, mi_sel, md_sel;
    logic [31:0]        t1, t2, r1, r2;
    logic               ge1, ge2;
    logic [62:0]        d_mag;
    logic signed [63:0] integ_sum;
    logic               out_load;

    localparam logic signed [33:0] ERR_MAX = $signed({3'b000, 31'h7FFF_FFFF});
    localparam logic signed [33:0] ERR_MIN = $signed({3'b111, 31'h0000_0000});

    // ---------------------------------------------------------------- dead zone
    always_comb begin
        e34   = {e_reg[32], e_reg};
        db34  = $signed({3'b000, dead_band_reg});
        dz_hi = e34 - db34;
        dz_lo = e34 + db34;
        if (e34 > db34) begin
            dz = dz_hi;
        end else if (e34 < -db34) begin
            dz = dz_lo;
        end else begin
            dz = '0;
        end
        // saturate to the 32-bit error range
        if (dz > ERR_MAX) begin
            err_dz = ERR_MAX[31:0];
        end else if (dz < ERR_MIN) begin
            err_dz = ERR_MIN[31:0];
        end else begin
            err_dz = dz[31:0];
        end
    end

    // ---------------------------------------------------------------- magnitudes
    assign err_abs  = abs33({err_reg[31], err_reg});
    assign s_abs    = abs33(s_reg);
    assign diff_abs = abs33(diff_reg);
    assign kp_abs   = abs33({prop_gain_reg[31], prop_gain_reg});
    assign ki_abs   = abs33({integ_gain_reg[31], integ_gain_reg});
    assign kd_abs   = abs33({deriv_gain_reg[31], deriv_gain_reg});

    // ---------------------------------------------------------------- product use
    // proportional term rounded to Q16.16
    assign p_round = prod_reg + pdz_pkg::ROUND_Q16;
    // ki*|s|: when |s| is exactly 2^32 the low half is zero and the product is ki<<32
    assign mi_sel  = s_mag_reg[32] ? {ki_mag_reg, 32'd0} : prod_reg;
    // low partial product of (ki*s)*dt plus the rounding bias
    assign x_sum   = prod_reg + pdz_pkg::BIAS_2_32;
    // high partial product plus carry from the low one
    assign a_sum   = prod_reg + {32'd0, xh_reg};
    // kd*|diff|, same corner as for the integral
    assign md_sel  = diff_mag_reg[32] ? {kd_mag_reg, 32'd0} : prod_reg;

    // ---------------------------------------------------------------- divider step
    // restoring division, remainder stays below dt
    always_comb begin
        t1  = {rem_reg, div_reg[63]};
        ge1 = (t1 >= {1'b0, dt_reg});
        r1  = ge1 ? (t1 - {1'b0, dt_reg}) : t1;
        t2  = {r1[30:0], div_reg[62]};
        ge2 = (t2 >= {1'b0, dt_reg});
        r2  = ge2 ? (t2 - {1'b0, dt_reg}) : t2;
    end

    // derivative magnitude saturated at 2^62
    assign d_mag = (div_reg > pdz_pkg::DERIV_CAP) ? pdz_pkg::DERIV_CAP[62:0] : div_reg[62:0];

    // integral accumulate before the clamp
    assign integ_sum = {{32{integral_reg[31]}}, integral_reg} + {inc_reg[62], inc_reg};

    // ---------------------------------------------------------------- sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pdz_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        out_load   = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        case (state_reg)
            pdz_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    state_next = pdz_pkg::ST_DEAD;
                end
            end
            pdz_pkg::ST_DEAD:  state_next = pdz_pkg::ST_SUMS;
            pdz_pkg::ST_SUMS:  state_next = pdz_pkg::ST_MAGS;
            pdz_pkg::ST_MAGS:  state_next = pdz_pkg::ST_MUL_P;
            pdz_pkg::ST_MUL_P: begin
                mul_a      = kp_mag_reg;
                mul_b      = err_mag_reg;
                state_next = pdz_pkg::ST_MUL_I;
            end
            pdz_pkg::ST_MUL_I: begin
                mul_a      = ki_mag_reg;
                mul_b      = s_mag_reg[31:0];
                state_next = pdz_pkg::ST_MUL_ILO;
            end
            pdz_pkg::ST_MUL_ILO: begin
                mul_a      = mi_sel[31:0];
                mul_b      = {1'b0, dt_reg};
                state_next = pdz_pkg::ST_MUL_IHI;
            end
            pdz_pkg::ST_MUL_IHI: begin
                mul_a      = mi_reg[63:32];
                mul_b      = {1'b0, dt_reg};
                state_next = pdz_pkg::ST_MUL_D;
            end
            pdz_pkg::ST_MUL_D: begin
                mul_a      = kd_mag_reg;
                mul_b      = diff_mag_reg[31:0];
                state_next = pdz_pkg::ST_DIV_SETUP;
            end
            pdz_pkg::ST_DIV_SETUP: begin
                // zero time step: no derivative, skip the divider
                if (dt_reg == '0) begin
                    state_next = pdz_pkg::ST_DCAP;
                end else begin
                    state_next = pdz_pkg::ST_DIV;
                end
            end
            pdz_pkg::ST_DIV: begin
                if (cnt_reg == pdz_pkg::DIV_LAST) begin
                    state_next = pdz_pkg::ST_DCAP;
                end
            end
            pdz_pkg::ST_DCAP:   state_next = pdz_pkg::ST_SUM_PI;
            pdz_pkg::ST_SUM_PI: state_next = pdz_pkg::ST_SUM_D;
            pdz_pkg::ST_SUM_D:  state_next = pdz_pkg::ST_CLAMP;
            pdz_pkg::ST_CLAMP: begin
                // wait only while an earlier result still occupies the output
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = pdz_pkg::ST_IDLE;
                end
            end
            default: state_next = pdz_pkg::ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------- control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prop_gain_reg    <= '0;
            integ_gain_reg   <= '0;
            deriv_gain_reg   <= '0;
            output_limit_reg <= pdz_pkg::LIMIT_RESET;
            dead_band_reg    <= '0;
            prev_err_reg     <= '0;
            integral_reg     <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    pdz_pkg::CFG_PROP_GAIN:    prop_gain_reg    <= cfg_wr_data;
                    pdz_pkg::CFG_INTEG_GAIN:   integ_gain_reg   <= cfg_wr_data;
                    pdz_pkg::CFG_DERIV_GAIN:   deriv_gain_reg   <= cfg_wr_data;
                    pdz_pkg::CFG_OUTPUT_LIMIT: output_limit_reg <= cfg_wr_data[30:0];
                    pdz_pkg::CFG_DEAD_BAND:    dead_band_reg    <= cfg_wr_data[30:0];
                    default: ;
                endcase
            end
            // old error already folded into the sums
            if (state_reg == pdz_pkg::ST_MAGS) begin
                prev_err_reg <= err_reg;
            end
            if (state_reg == pdz_pkg::ST_DCAP) begin
                integral_reg <= clamp_lim(integ_sum, output_limit_reg);
            end
            // a new result refills the slot as the old one leaves
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- datapath
    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        case (state_reg)
            pdz_pkg::ST_IDLE: begin
                if (s_valid) begin
                    dt_reg <= s_time_step;
                    e_reg  <= {s_target[31], s_target} - {s_feedback[31], s_feedback};
                end
            end
            pdz_pkg::ST_DEAD: begin
                err_reg <= err_dz;
            end
            pdz_pkg::ST_SUMS: begin
                s_reg    <= {err_reg[31], err_reg} + {prev_err_reg[31], prev_err_reg};
                diff_reg <= {err_reg[31], err_reg} - {prev_err_reg[31], prev_err_reg};
            end
            pdz_pkg::ST_MAGS: begin
                err_mag_reg  <= err_abs[31:0];
                s_mag_reg    <= s_abs;
                diff_mag_reg <= diff_abs;
                kp_mag_reg   <= kp_abs[31:0];
                ki_mag_reg   <= ki_abs[31:0];
                kd_mag_reg   <= kd_abs[31:0];
                sp_reg       <= prop_gain_reg[31] ^ err_reg[31];
                si_reg       <= integ_gain_reg[31] ^ s_reg[32];
                sd_reg       <= deriv_gain_reg[31] ^ diff_reg[32];
            end
            pdz_pkg::ST_MUL_I: begin
                p_mag_reg <= p_round[62:16];
            end
            pdz_pkg::ST_MUL_ILO: begin
                mi_reg <= mi_sel;
            end
            pdz_pkg::ST_MUL_IHI: begin
                xh_reg <= x_sum[63:32];
            end
            pdz_pkg::ST_MUL_D: begin
                // half of the trapezoid folded in here
                inc_mag_reg <= a_sum[62:1];
            end
            pdz_pkg::ST_DIV_SETUP: begin
                div_reg <= md_sel + {34'd0, dt_reg[30:1]};
                rem_reg <= '0;
                cnt_reg <= '0;
                inc_reg <= si_reg ? -$signed({1'b0, inc_mag_reg})
                                  :  $signed({1'b0, inc_mag_reg});
            end
            pdz_pkg::ST_DIV: begin
                div_reg <= {div_reg[61:0], ge1, ge2};
                rem_reg <= r2[30:0];
                cnt_reg <= cnt_reg + 1'b1;
            end
            pdz_pkg::ST_DCAP: begin
                if (dt_reg == '0) begin
                    d_reg <= '0;
                end else begin
                    d_reg <= sd_reg ? -$signed({1'b0, d_mag}) : $signed({1'b0, d_mag});
                end
                p_reg <= sp_reg ? -$signed({1'b0, p_mag_reg}) : $signed({1'b0, p_mag_reg});
            end
            pdz_pkg::ST_SUM_PI: begin
                acc_reg <= {{16{p_reg[47]}}, p_reg} + {{32{integral_reg[31]}}, integral_reg};
            end
            pdz_pkg::ST_SUM_D: begin
                acc_reg <= acc_reg + d_reg;
            end
            pdz_pkg::ST_CLAMP: begin
                if (out_load) begin
                    drive_reg <= clamp_lim(acc_reg, output_limit_reg);
                end
            end
            default: ;
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_drive = drive_reg;

endmodule

### design/pdz_checker.sv
// ----------------------------------------------------------------------------
// pdz_checker
// port-level checks on the dead-zone pid controller
// ----------------------------------------------------------------------------
module pdz_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_drive
);

    // reset empties the output and leaves the block ready
    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("output not empty or block not ready after reset");

    // block is busy straight after taking a request
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted while previous one in progress");

    // still busy a few cycles on, the work spans many cycles
    a_busy_later: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |-> ##8 !s_ready)
        else $error("request finished too early");

    // stalled result holds
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_drive))
        else $error("stalled result dropped or changed");

endmodule

bind pid_dead_zone_controller pdz_checker u_pdz_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_drive (m_drive)
);
